@@ rtl/opmh_pkg.sv @@
// opmh_pkg: shared constants, types and helpers for the one-permutation minhash sketch core
// no dependencies; imported by every module of the core
package opmh_pkg;

	localparam int MAX_SUFFIX_BITS = 10;
	localparam int MIN_SUFFIX_BITS = 3;
	localparam int NUM_SLOTS       = 2;
	localparam int SLOT_W          = $clog2(NUM_SLOTS);
	localparam int BIN_W           = MAX_SUFFIX_BITS;
	localparam int ADDR_W          = SLOT_W + BIN_W;
	localparam int STORE_DEPTH     = NUM_SLOTS << MAX_SUFFIX_BITS;
	localparam int WORD_W          = 64;
	localparam int CNT_W           = 11;
	localparam int SUFFIX_W        = 4;
	localparam int PREFIX_KEEP     = 62;

	localparam logic [SUFFIX_W-1:0] SUFFIX_RESET = SUFFIX_W'(5);
	localparam logic [WORD_W-1:0]   EMPTY_BIN    = '1;

	// request kinds
	localparam logic [1:0] REQ_INSERT  = 2'd0;
	localparam logic [1:0] REQ_CLEAR   = 2'd1;
	localparam logic [1:0] REQ_COMPARE = 2'd2;

	typedef struct packed {
		logic both_filled;
		logic masked_eq;
		logic prefix_lt;
	} cmp_res_t;

	// effective bin-select width, clamped to the supported range
	function automatic logic [SUFFIX_W-1:0] eff_bits(input logic [SUFFIX_W-1:0] s);
		logic [SUFFIX_W-1:0] n;
		n = s;
		if (n < SUFFIX_W'(MIN_SUFFIX_BITS)) n = SUFFIX_W'(MIN_SUFFIX_BITS);
		if (n > SUFFIX_W'(MAX_SUFFIX_BITS)) n = SUFFIX_W'(MAX_SUFFIX_BITS);
		return n;
	endfunction

	// index of the last bin in use
	function automatic logic [BIN_W-1:0] last_bin(input logic [SUFFIX_W-1:0] n);
		logic [BIN_W:0] t;
		t = (BIN_W + 1)'(1) << n;
		return BIN_W'(t - (BIN_W + 1)'(1));
	endfunction

	// mask of the low (62 - n) prefix bits
	function automatic logic [WORD_W-1:0] pfx_mask(input logic [SUFFIX_W-1:0] n);
		logic [6:0] sh;
		sh = 7'(PREFIX_KEEP) - 7'(n);
		return (WORD_W'(1) << sh) - WORD_W'(1);
	endfunction

endpackage

@@ rtl/opmh_store.sv @@
// opmh_store: sketch bin memory, one write port and two registered read ports
// depends on opmh_pkg
module opmh_store
	import opmh_pkg::*;
(
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WORD_W-1:0] wdata,
	input  logic [ADDR_W-1:0] raddr_a,
	input  logic [ADDR_W-1:0] raddr_b,
	output logic [WORD_W-1:0] rdata_a,
	output logic [WORD_W-1:0] rdata_b
);

	logic [WORD_W-1:0] mem [STORE_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

@@ rtl/opmh_unit.sv @@
// opmh_unit: shared compare unit for bin words (empty test, masked match, min test)
// depends on opmh_pkg
module opmh_unit
	import opmh_pkg::*;
(
	input  logic [WORD_W-1:0] va,
	input  logic [WORD_W-1:0] vb,
	input  logic [WORD_W-1:0] prefix,
	input  logic [WORD_W-1:0] mask,
	output cmp_res_t          res
);

	always_comb begin
		res.both_filled = (va != EMPTY_BIN) && (vb != EMPTY_BIN);
		res.masked_eq   = ((va ^ vb) & mask) == '0;
		res.prefix_lt   = prefix < va;
	end

endmodule

@@ rtl/one_permutation_minhash_sketch_core.sv @@
// one_permutation_minhash_sketch_core: top level, request sequencer and bin counters
// depends on opmh_pkg, opmh_store, opmh_unit
//
// Keeps two one-permutation MinHash sketches of 2^n bins (n = suffix_bits clamped to 3..10)
// in a 2048 x 64 memory. After reset the core runs a clearing pass over all 2048 entries, one
// entry a cycle, with s_tready low; configuration writes are taken during it. One request is
// worked at a time and s_tready is low while it runs. An insert reads the bin, then writes the
// smaller value. A clear writes every bin of slot_a, whatever n is, one bin a cycle through
// the single write port. A compare reads both slots through the two read ports, one bin a
// cycle, and then shows the result on m_tvalid, where it waits for m_tready. Only compare
// requests give a result; request kind 3 is taken and ignored.
module one_permutation_minhash_sketch_core
	import opmh_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [SUFFIX_W-1:0] cfg_wdata,   // suffix_bits
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [71:0]         s_tdata,     // hash_value[63:0], slot_a[64], slot_b[65], zero pad
	input  logic [1:0]          s_tuser,     // req_type[1:0]
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [23:0]         m_tdata      // common_bins[10:0], compared_bins[21:11], zero pad
);

	localparam logic [2:0] ST_INIT     = 3'd0;
	localparam logic [2:0] ST_IDLE     = 3'd1;
	localparam logic [2:0] ST_INS      = 3'd2;
	localparam logic [2:0] ST_CLR      = 3'd3;
	localparam logic [2:0] ST_CMP      = 3'd4;
	localparam logic [2:0] ST_CMP_LAST = 3'd5;
	localparam logic [2:0] ST_OUT      = 3'd6;

	logic [2:0]          state_q;
	logic [ADDR_W-1:0]   cnt_q;
	logic [SUFFIX_W-1:0] suffix_q;
	logic [SLOT_W-1:0]   slot_a_q;
	logic [SLOT_W-1:0]   slot_b_q;
	logic [BIN_W-1:0]    bin_q;
	logic [BIN_W-1:0]    last_bin_q;
	logic [WORD_W-1:0]   prefix_q;
	logic [WORD_W-1:0]   mask_q;
	logic                acc_en_s1;
	logic [CNT_W-1:0]    common_q;
	logic [CNT_W-1:0]    compared_q;

	logic [SUFFIX_W-1:0] n_w;
	logic [WORD_W-1:0]   hash_w;
	logic [SLOT_W-1:0]   slot_a_w;
	logic [SLOT_W-1:0]   slot_b_w;
	logic [BIN_W-1:0]    bin_w;
	logic                accept;

	logic                mem_we;
	logic [ADDR_W-1:0]   mem_waddr;
	logic [WORD_W-1:0]   mem_wdata;
	logic [ADDR_W-1:0]   raddr_a;
	logic [ADDR_W-1:0]   raddr_b;
	logic [WORD_W-1:0]   rdata_a;
	logic [WORD_W-1:0]   rdata_b;
	cmp_res_t            res;

	// slot fields are narrower than the slot count, so no wrap is needed
	assign n_w      = eff_bits(suffix_q);
	assign hash_w   = s_tdata[63:0];
	assign slot_a_w = SLOT_W'(s_tdata[64]);
	assign slot_b_w = SLOT_W'(s_tdata[65]);
	assign bin_w    = hash_w[BIN_W-1:0] & last_bin(n_w);

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = (state_q == ST_OUT);
	assign m_tdata  = {2'b00, compared_q, common_q};

	// the insert read goes out in the accept cycle
	assign raddr_a = (state_q == ST_IDLE) ? {slot_a_w, bin_w} : {slot_a_q, cnt_q[BIN_W-1:0]};
	assign raddr_b = {slot_b_q, cnt_q[BIN_W-1:0]};

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = cnt_q;
		mem_wdata = EMPTY_BIN;
		case (state_q)
			ST_INIT: begin
				mem_we = 1'b1;
			end
			ST_CLR: begin
				mem_we    = 1'b1;
				mem_waddr = {slot_a_q, cnt_q[BIN_W-1:0]};
			end
			ST_INS: begin
				mem_we    = res.prefix_lt;
				mem_waddr = {slot_a_q, bin_q};
				mem_wdata = prefix_q;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	opmh_store u_store (
		.clk     (clk),
		.we      (mem_we),
		.waddr   (mem_waddr),
		.wdata   (mem_wdata),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	opmh_unit u_unit (
		.va     (rdata_a),
		.vb     (rdata_b),
		.prefix (prefix_q),
		.mask   (mask_q),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			suffix_q <= SUFFIX_RESET;
		end else if (cfg_we) begin
			suffix_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			slot_a_q   <= slot_a_w;
			slot_b_q   <= slot_b_w;
			bin_q      <= bin_w;
			last_bin_q <= last_bin(n_w);
			prefix_q   <= hash_w >> n_w;
			mask_q     <= pfx_mask(n_w);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_INIT;
			cnt_q      <= '0;
			acc_en_s1  <= 1'b0;
			common_q   <= '0;
			compared_q <= '0;
		end else begin
			acc_en_s1 <= (state_q == ST_CMP);
			if (acc_en_s1 && res.both_filled) begin
				compared_q <= compared_q + CNT_W'(1);
				if (res.masked_eq) begin
					common_q <= common_q + CNT_W'(1);
				end
			end
			case (state_q)
				ST_INIT: begin
					cnt_q <= cnt_q + ADDR_W'(1);
					if (cnt_q == ADDR_W'(STORE_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						cnt_q <= '0;
						case (s_tuser)
							REQ_INSERT: begin
								state_q <= ST_INS;
							end
							REQ_CLEAR: begin
								state_q <= ST_CLR;
							end
							REQ_COMPARE: begin
								state_q    <= ST_CMP;
								common_q   <= '0;
								compared_q <= '0;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_INS: begin
					state_q <= ST_IDLE;
				end
				ST_CLR: begin
					cnt_q <= cnt_q + ADDR_W'(1);
					if (cnt_q[BIN_W-1:0] == '1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_CMP: begin
					cnt_q <= cnt_q + ADDR_W'(1);
					if (cnt_q[BIN_W-1:0] == last_bin_q) begin
						state_q <= ST_CMP_LAST;
					end
				end
				ST_CMP_LAST: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (m_tready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// a result is never offered while a new request can be taken
	a_out_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(m_tvalid && s_tready))
		else $error("result offered while accepting requests");

	// the store is never written while a compare walks it
	a_no_write_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CMP || state_q == ST_CMP_LAST) |-> !mem_we)
		else $error("store written during compare");

	// matching bins are a subset of compared bins
	a_count_order: assert property (@(posedge clk) disable iff (!arst_n)
		common_q <= compared_q)
		else $error("common count exceeds compared count");

	// a compare request starts the bin walk in the next cycle
	a_cmp_start: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s_tuser == REQ_COMPARE) |=> (state_q == ST_CMP && cnt_q == '0))
		else $error("compare walk did not start");

endmodule
